### src/ridsf_pkg.sv
// Shared constants, types and codes of the ROM identification string finder.
`timescale 1ns / 1ps
`default_nettype none

package ridsf_pkg;

    localparam int ROM_BYTES   = 65536;
    localparam int PATTERN_MAX = 16;
    localparam int STRING_MAX  = 256;

    localparam int POS_W = $clog2(ROM_BYTES);
    localparam int CNT_W = POS_W + 1;
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PAT_BITS = 64;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam int RQ_DEPTH = 2;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = RQ_AW + 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_EXTEND = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    // One classified byte as it travels from the front part to the back part.
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] found_start;
        logic [CNT_W-1:0] found_length;
        logic [CNT_W-1:0] space_run;
        logic [CNT_W-1:0] end_pos;
        logic             printable;
        logic             space;
        logic             term;
        logic             last;
    } item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] string_start;
        logic [CNT_W-1:0] string_length;
        logic [CNT_W-1:0] resume_offset;
    } result_t;

endpackage

`default_nettype wire

### src/ridsf_front.sv
// Front part: byte window, printable and space runs, pattern compare per byte.
`timescale 1ns / 1ps
`default_nettype none

module ridsf_front
    import ridsf_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [7:0]          data_byte,
    input  wire logic                last_byte,
    input  wire logic                accept,
    input  wire logic [PAT_BITS-1:0] pattern_low,
    input  wire logic [PAT_BITS-1:0] pattern_high,
    input  wire logic [LEN_W-1:0]    pattern_length,
    output item_t                    item
);

    logic [POS_W-1:0] pos_reg;
    logic [CNT_W-1:0] prun_reg;
    logic [CNT_W-1:0] srun_reg;
    logic [7:0]       win_reg  [PATTERN_MAX-1];
    logic [CNT_W-1:0] hist_reg [PATTERN_MAX-1];

    logic [7:0]       win_next  [PATTERN_MAX];
    logic [CNT_W-1:0] hist_next [PATTERN_MAX];
    logic [7:0]       pat_byte  [PATTERN_MAX];
    logic [2*PAT_BITS-1:0] pat_all;
    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] len_m1;
    logic             printable;
    logic             space;
    logic             last_eff;
    logic             match;
    logic [CNT_W-1:0] prun_next;
    logic [CNT_W-1:0] srun_next;
    logic [CNT_W-1:0] run_before;
    logic [CNT_W-1:0] fl;
    logic [CNT_W-1:0] end_pos;
    logic [CNT_W-1:0] fs_wide;

    always_comb
    begin
        if (pattern_length == '0)
            len = LEN_W'(1);
        else if (pattern_length > LEN_W'(PATTERN_MAX))
            len = LEN_W'(PATTERN_MAX);
        else
            len = pattern_length;
    end

    assign len_m1 = IDX_W'(len - LEN_W'(1));

    assign pat_all = {pattern_high, pattern_low};

    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            pat_byte[k] = pat_all[8*k +: 8];
        end
    end

    // The window as it stands once the new byte is in, newest at index 0.
    always_comb
    begin
        win_next[0]  = data_byte;
        hist_next[0] = prun_reg;
        for (int j = 1; j < PATTERN_MAX; j++)
        begin
            win_next[j]  = win_reg[j-1];
            hist_next[j] = hist_reg[j-1];
        end
    end

    always_comb
    begin
        logic [IDX_W-1:0] idx;
        match = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            idx = len_m1 - IDX_W'(k);
            if ((LEN_W'(k) < len) && (win_next[idx] != pat_byte[k]))
                match = 1'b0;
        end
    end

    assign printable = (data_byte >= CH_SPACE) && (data_byte <= CH_TILDE);
    assign space     = (data_byte == CH_SPACE);
    assign last_eff  = last_byte || (pos_reg == POS_W'(ROM_BYTES - 1));
    assign prun_next = printable ? prun_reg + CNT_W'(1) : '0;
    assign srun_next = space ? srun_reg + CNT_W'(1) : '0;

    // The printable run that ends just before the match start widens it backward.
    assign run_before = hist_next[len_m1];
    assign fl         = CNT_W'(len) + run_before;
    assign end_pos    = CNT_W'(pos_reg) + CNT_W'(1);
    assign fs_wide    = end_pos - fl;

    always_comb
    begin
        item.hit          = match && (pos_reg >= POS_W'(len_m1));
        item.found_start  = fs_wide[POS_W-1:0];
        item.found_length = fl;
        item.space_run    = srun_next;
        item.end_pos      = end_pos;
        item.printable    = printable;
        item.space        = space;
        item.term         = (data_byte == CH_NUL) || (data_byte == CH_LF)
                            || (data_byte == CH_CR);
        item.last         = last_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            prun_reg <= '0;
            srun_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg  <= last_eff ? '0 : pos_reg + POS_W'(1);
            prun_reg <= last_eff ? '0 : prun_next;
            srun_reg <= last_eff ? '0 : srun_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int j = 0; j < PATTERN_MAX - 1; j++)
            begin
                win_reg[j]  <= win_next[j];
                hist_reg[j] <= hist_next[j];
            end
        end
    end

endmodule

`default_nettype wire

### src/ridsf_item_fifo.sv
// Short queue of classified bytes between the front and the back part.
`timescale 1ns / 1ps
`default_nettype none

module ridsf_item_fifo
    import ridsf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire item_t wr_item,
    output logic       full,
    input  wire logic  rd_en,
    output item_t      rd_item,
    output logic       empty
);

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic               do_wr;
    logic               do_rd;

    assign full    = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + FIFO_CW'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

`default_nettype wire

### src/ridsf_back.sv
// Back part: search phase control, forward widening, verdict and result queue.
`timescale 1ns / 1ps
`default_nettype none

module ridsf_back
    import ridsf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire item_t item,
    input  wire logic  item_valid,
    output logic       item_take,
    output result_t    result,
    output logic       result_empty,
    input  wire logic  result_pop
);

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [POS_W-1:0] fs_reg;
    logic [POS_W-1:0] fs_next;
    logic [CNT_W-1:0] fl_reg;
    logic [CNT_W-1:0] fl_next;
    logic [CNT_W-1:0] end_reg;
    logic [CNT_W-1:0] end_next;
    logic [CNT_W-1:0] keep_reg;
    logic [CNT_W-1:0] keep_next;

    result_t          rq_reg [RQ_DEPTH];
    logic [RQ_AW-1:0] rq_wr_reg;
    logic [RQ_AW-1:0] rq_rd_reg;
    logic [RQ_CW-1:0] rq_count_reg;

    logic             emit;
    result_t          res;
    logic             do_pop;
    logic [CNT_W-1:0] fl_inc;
    logic             grow;

    assign item_take    = item_valid && (rq_count_reg != RQ_CW'(RQ_DEPTH));
    assign result_empty = (rq_count_reg == '0);
    assign result       = rq_reg[rq_rd_reg];
    assign do_pop       = result_pop && !result_empty;

    assign fl_inc = fl_reg + CNT_W'(1);
    assign grow   = item.printable && (fl_reg < CNT_W'(STRING_MAX));

    // keep_reg tracks the string length without its trailing spaces, and
    // end_reg the offset just past the widened string.
    always_comb
    begin
        phase_next = phase_reg;
        fs_next    = fs_reg;
        fl_next    = fl_reg;
        end_next   = end_reg;
        keep_next  = keep_reg;
        emit       = 1'b0;
        res        = '0;
        if (item_take)
        begin
            unique case (phase_reg)
                PH_SEARCH:
                begin
                    if (item.hit)
                    begin
                        fs_next   = item.found_start;
                        fl_next   = item.found_length;
                        end_next  = item.end_pos;
                        keep_next = item.found_length - item.space_run;
                        if (item.last)
                        begin
                            emit = 1'b1;
                            res  = '{1'b1, item.found_start, keep_next, item.end_pos};
                        end
                        else
                        begin
                            phase_next = PH_EXTEND;
                        end
                    end
                    else if (item.last)
                    begin
                        emit = 1'b1;
                        res  = '{1'b0, '0, '0, item.end_pos};
                    end
                end
                PH_EXTEND:
                begin
                    if (grow)
                    begin
                        fl_next   = fl_inc;
                        end_next  = end_reg + CNT_W'(1);
                        keep_next = item.space ? keep_reg : fl_inc;
                        if (item.last)
                        begin
                            emit = 1'b1;
                            res  = '{1'b1, fs_reg, keep_next, end_next};
                        end
                    end
                    else
                    begin
                        emit       = 1'b1;
                        res        = '{item.term, fs_reg,
                                       item.term ? keep_reg : fl_reg, end_reg};
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_SEARCH;
                end
            endcase
            if (item.last)
                phase_next = PH_SEARCH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SEARCH;
            rq_wr_reg    <= '0;
            rq_rd_reg    <= '0;
            rq_count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (emit)
                rq_wr_reg <= rq_wr_reg + RQ_AW'(1);
            if (do_pop)
                rq_rd_reg <= rq_rd_reg + RQ_AW'(1);
            if (emit && !do_pop)
                rq_count_reg <= rq_count_reg + RQ_CW'(1);
            else if (do_pop && !emit)
                rq_count_reg <= rq_count_reg - RQ_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        fs_reg   <= fs_next;
        fl_reg   <= fl_next;
        end_reg  <= end_next;
        keep_reg <= keep_next;
        if (emit)
            rq_reg[rq_wr_reg] <= res;
    end

endmodule

`default_nettype wire

### src/rom_id_string_finder.sv
// Top level of the ROM identification string finder: configuration and wiring.
//
// ROM bytes enter one beat at a time on data_byte/last_byte with push/full;
// a beat is taken when push is high and full is low. last_byte closes a
// stream, and so does the byte at offset 65535 even without the mark.
// Each stream yields exactly one result beat on found, string_start,
// string_length and resume_offset, shown while empty is low and taken with
// pop. A result reaches the outputs through the byte queue and the result queue.
// The front part classifies and compares one byte per cycle, so one byte per
// cycle is sustained while the receiver keeps up; a four-entry byte queue and a
// two-entry result queue decouple the front from the back part and the back
// part from the receiver. When the receiver stalls, the result queue fills, the
// back part holds, the byte queue fills and full rises; nothing is dropped.
// The pattern is written through cfg_valid/cfg_ready/cfg_index/cfg_data (index 0:
// bytes 0..7, 1: bytes 8..15, 2: length); the user must write it only while idle;
// the block does not check it. cfg_ready is always high. Reset clears the pattern
// to zero with length 1 and starts a fresh stream; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module rom_id_string_finder
    import ridsf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 last_byte,
    input  wire logic                 push,
    output logic                      full,
    output logic                      found,
    output logic [POS_W-1:0]          string_start,
    output logic [CNT_W-1:0]          string_length,
    output logic [CNT_W-1:0]          resume_offset,
    output logic                      empty,
    input  wire logic                 pop,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PAT_BITS-1:0]  cfg_data
);

    logic [PAT_BITS-1:0] pattern_low_reg;
    logic [PAT_BITS-1:0] pattern_high_reg;
    logic [LEN_W-1:0]    pattern_length_reg;

    item_t   front_item;
    item_t   back_item;
    logic    accept;
    logic    fifo_empty;
    logic    item_take;
    result_t result;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= LEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                default:            pattern_length_reg <= pattern_length_reg;
            endcase
        end
    end

    ridsf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .accept         (accept),
        .pattern_low    (pattern_low_reg),
        .pattern_high   (pattern_high_reg),
        .pattern_length (pattern_length_reg),
        .item           (front_item)
    );

    ridsf_item_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_item (front_item),
        .full    (full),
        .rd_en   (item_take),
        .rd_item (back_item),
        .empty   (fifo_empty)
    );

    ridsf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (back_item),
        .item_valid   (!fifo_empty),
        .item_take    (item_take),
        .result       (result),
        .result_empty (empty),
        .result_pop   (pop)
    );

    assign found         = result.found;
    assign string_start  = result.string_start;
    assign string_length = result.string_length;
    assign resume_offset = result.resume_offset;

endmodule

`default_nettype wire

### tb/rom_id_string_finder_tb.sv
// Self-checking testbench of the ROM identification string finder.
`timescale 1ns / 1ps

module rom_id_string_finder_tb;
    import ridsf_pkg::*;

    typedef logic [7:0] byte_q_t [$];

    localparam int CYCLE_LIMIT   = 1500000;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int PHASE_ITEMS   = 250;
    localparam int SETTLE_CYCLES = 20;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic [7:0]           data_byte = '0;
    logic                 last_byte = 1'b0;
    logic                 push      = 1'b0;
    logic                 pop       = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PATTERN_LOW;
    logic [PAT_BITS-1:0]  cfg_data  = '0;
    logic                 full;
    logic                 found;
    logic [POS_W-1:0]     string_start;
    logic [CNT_W-1:0]     string_length;
    logic [CNT_W-1:0]     resume_offset;
    logic                 empty;
    logic                 cfg_ready;

    always #10 clk = ~clk;

    rom_id_string_finder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .push          (push),
        .full          (full),
        .found         (found),
        .string_start  (string_start),
        .string_length (string_length),
        .resume_offset (resume_offset),
        .empty         (empty),
        .pop           (pop),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Copy of the pattern registers.
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [4:0]  pat_len_code;

    // Copy of the per-stream scan state.
    logic [7:0]  win_byte [PATTERN_MAX];
    int unsigned win_run [PATTERN_MAX];
    int unsigned scan_pos;
    int unsigned run_len;
    int unsigned str_start;
    int unsigned str_len;
    int unsigned space_run;
    phase_t      scan_phase;

    result_t     pending_results [$];
    int          errors = 0;
    int          items_sent = 0;
    int          streams_sent = 0;
    int          results_checked = 0;
    int          pattern_settings = 0;
    int          cycle_count = 0;
    bit          no_idle = 1'b0;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic bit is_printable(input logic [7:0] b);
        return b >= CH_SPACE && b <= CH_TILDE;
    endfunction

    function automatic logic [7:0] pattern_char(input int unsigned k);
        if (k < 8)
            return pat_lo[8*k +: 8];
        return pat_hi[8*(k-8) +: 8];
    endfunction

    function automatic int unsigned active_len();
        if (pat_len_code == 5'd0)
            return 1;
        if (pat_len_code > PATTERN_MAX)
            return PATTERN_MAX;
        return pat_len_code;
    endfunction

    function automatic void clear_stream();
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            win_byte[i] = '0;
            win_run[i]  = 0;
        end
        scan_pos   = 0;
        run_len    = 0;
        str_start  = 0;
        str_len    = 0;
        space_run  = 0;
        scan_phase = PH_SEARCH;
    endfunction

    function automatic result_t close_string(input bit accept);
        result_t r;
        scan_phase      = PH_DONE;
        r.found         = accept;
        r.string_start  = POS_W'(str_start);
        r.string_length = CNT_W'(accept ? str_len - space_run : str_len);
        r.resume_offset = CNT_W'(str_start + str_len);
        return r;
    endfunction

    // Advances the scan by one byte; returns 1 when the byte decides a result.
    function automatic bit scan_byte(input logic [7:0] d, input logic mark, output result_t r);
        int unsigned p;
        int unsigned n;
        int unsigned run_before;
        int unsigned mstart;
        bit          stream_end;
        bit          hit;
        bit          has;
        p          = scan_pos;
        stream_end = mark || p >= ROM_BYTES - 1;
        has        = 1'b0;
        r          = '0;
        if (scan_phase == PH_SEARCH)
        begin
            n = active_len();
            for (int i = PATTERN_MAX - 1; i > 0; i--)
            begin
                win_byte[i] = win_byte[i-1];
                win_run[i]  = win_run[i-1];
            end
            win_byte[0] = d;
            win_run[0]  = run_len;
            run_len     = is_printable(d) ? run_len + 1 : 0;
            space_run   = (d == CH_SPACE) ? space_run + 1 : 0;
            if (p + 1 >= n)
            begin
                hit = 1'b1;
                for (int unsigned k = 0; k < n; k++)
                    if (win_byte[n-1-k] != pattern_char(k))
                        hit = 1'b0;
                if (hit)
                begin
                    // Widen backward over the printable run just before the match.
                    run_before = win_run[n-1];
                    mstart     = p + 1 - n;
                    if (run_before > mstart)
                        run_before = mstart;
                    str_start = mstart - run_before;
                    str_len   = n + run_before;
                    if (space_run > str_len)
                        space_run = str_len;
                    if (stream_end)
                    begin
                        r   = close_string(1'b1);
                        has = 1'b1;
                    end
                    else
                        scan_phase = PH_EXTEND;
                end
            end
        end
        else if (scan_phase == PH_EXTEND)
        begin
            if (is_printable(d) && str_len < STRING_MAX)
            begin
                str_len++;
                space_run = (d == CH_SPACE) ? space_run + 1 : 0;
                if (stream_end)
                begin
                    r   = close_string(1'b1);
                    has = 1'b1;
                end
            end
            else
            begin
                r   = close_string(d == CH_NUL || d == CH_LF || d == CH_CR);
                has = 1'b1;
            end
        end
        scan_pos = p + 1;
        if (stream_end)
        begin
            if (!has && scan_phase == PH_SEARCH)
            begin
                r.resume_offset = CNT_W'(p + 1);
                has = 1'b1;
            end
            clear_stream();
        end
        return has;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic mark);
        result_t r;
        while (!no_idle && $urandom_range(99) < 21)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        data_byte <= b;
        last_byte <= mark;
        do
            @(posedge clk);
        while (full);
        items_sent++;
        if (scan_byte(b, mark, r))
            pending_results.push_back(r);
    endtask

    task automatic send_stream(input byte_q_t s, input bit mark_end);
        for (int i = 0; i < s.size(); i++)
            send_byte(s[i], mark_end && i == s.size() - 1);
        streams_sent++;
    endtask

    // Holds the sender until every result is in and the byte queue has run dry.
    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_PATTERN_LOW:    pat_lo = val;
            CFG_PATTERN_HIGH:   pat_hi = val;
            CFG_PATTERN_LENGTH: pat_len_code = val[4:0];
            default: ;
        endcase
    endtask

    task automatic set_pattern(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [63:0] len_word);
        drain();
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_PATTERN_LENGTH, len_word);
        cfg_valid <= 1'b0;
        pattern_settings++;
    endtask

    function automatic byte_q_t text_bytes(input string txt);
        byte_q_t q;
        for (int i = 0; i < txt.len(); i++)
            q.push_back(txt[i]);
        return q;
    endfunction

    task automatic set_pattern_text(input string txt);
        logic [63:0] lo;
        logic [63:0] hi;
        lo = '0;
        hi = '0;
        for (int i = 0; i < txt.len(); i++)
            if (i < 8)
                lo[8*i +: 8] = txt[i];
            else
                hi[8*(i-8) +: 8] = txt[i];
        set_pattern(lo, hi, 64'(txt.len()));
    endtask

    function automatic logic [7:0] printable_rand();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    // Maybe junk, a printable run, the pattern, printable text, maybe an end byte, junk.
    task automatic build_id_stream(output byte_q_t s);
        int t;
        int lead;
        int tail;
        int n;
        s = {};
        if ($urandom_range(99) >= 40)
            repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(255)));
        t    = $urandom_range(99);
        lead = (t < 80) ? $urandom_range(0, 12) :
               (t < 95) ? $urandom_range(13, 60) : $urandom_range(200, 300);
        repeat (lead) s.push_back(printable_rand());
        n = active_len();
        for (int k = 0; k < n; k++)
            s.push_back(pattern_char(k));
        if ($urandom_range(99) < 10)
            s[s.size() - 1 - $urandom_range(n - 1)] ^= 8'(1 << $urandom_range(7));
        t    = $urandom_range(99);
        tail = (t < 88) ? $urandom_range(0, 20) : $urandom_range(230, 300);
        repeat (tail) s.push_back(printable_rand());
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(1, 4)) s.push_back(CH_SPACE);
        t = $urandom_range(99);
        if (t >= 15)
        begin
            if (t < 35)
                s.push_back(CH_NUL);
            else if (t < 50)
                s.push_back(CH_LF);
            else if (t < 65)
                s.push_back(CH_CR);
            else if (t < 80)
                s.push_back(8'($urandom_range(8'h80, 8'hFF)));
            else if (t < 90)
                s.push_back(8'($urandom_range(8'h01, 8'h1F)));
            else
                s.push_back(8'h7F);
            repeat ($urandom_range(0, 5)) s.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic build_noise_stream(output byte_q_t s);
        bit text_only;
        s = {};
        text_only = $urandom_range(1);
        repeat ($urandom_range(1, 40))
            s.push_back(text_only ? printable_rand() : 8'($urandom_range(255)));
    endtask

    task automatic test_defaults();
        byte_q_t s;
        // Reset pattern is a single NUL byte.
        s = {8'h41, CH_NUL, 8'hFF};
        send_stream(s, 1'b1);
        s = {8'hFF};
        send_stream(s, 1'b1);
    endtask

    task automatic test_terminators();
        byte_q_t s;
        set_pattern_text("ID");
        // Match on the very last byte of the stream.
        s = text_bytes(" xID");
        send_stream(s, 1'b1);
        s = text_bytes("ab ID  ");
        s.push_back(CH_CR);
        send_stream(s, 1'b1);
        s = text_bytes("ID");
        s.push_back(CH_LF);
        s.push_back(8'h49);
        send_stream(s, 1'b1);
        s = {8'h80, 8'h49, 8'h44, CH_NUL};
        send_stream(s, 1'b1);
        s = text_bytes("ID~");
        s.push_back(8'h7F);
        s.push_back(8'hFF);
        send_stream(s, 1'b1);
    endtask

    task automatic test_no_match();
        byte_q_t s;
        s = text_bytes("hello");
        send_stream(s, 1'b1);
    endtask

    task automatic test_length_codes();
        byte_q_t s;
        // Length code 31 saturates to the full sixteen bytes.
        set_pattern(64'hFFFF_FFFF_FFFF_FFFF, 64'h7E7E_7E7E_7E7E_7E7E, 64'hFFFF_FFFF_FFFF_FFFF);
        s = {};
        repeat (8) s.push_back(8'hFF);
        repeat (8) s.push_back(CH_TILDE);
        s.push_back(CH_LF);
        send_stream(s, 1'b1);
        // Length code 0 acts as a single byte.
        set_pattern(64'h0000_0000_0000_0051, 64'h0, 64'hFFFF_FFFF_FFFF_FFE0);
        s = text_bytes("aQ");
        s.push_back(CH_LF);
        send_stream(s, 1'b1);
    endtask

    task automatic test_rom_end();
        byte_q_t s;
        // The string is still growing, with trailing spaces, when the stream ends.
        set_pattern_text("XYZ");
        s = text_bytes("ab XYZcd  ");
        send_stream(s, 1'b1);
        s = text_bytes("XYZ");
        s.push_back(CH_CR);
        send_stream(s, 1'b1);
    endtask

    task automatic test_random_streams();
        byte_q_t     s;
        int          rand_start;
        int          phase_start;
        int          phase_no;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] len_word;
        logic [4:0]  code;
        rand_start = items_sent;
        phase_no   = 0;
        while (items_sent - rand_start < RANDOM_ITEMS)
        begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            if ($urandom_range(99) < 80)
                for (int i = 0; i < 8; i++)
                begin
                    lo[8*i +: 8] = printable_rand();
                    hi[8*i +: 8] = printable_rand();
                end
            if (phase_no == 0)
                code = 5'd16;
            else if (phase_no == 1)
                code = 5'd1;
            else if ($urandom_range(99) < 15)
                code = ($urandom_range(1) != 0) ? 5'd0 : 5'($urandom_range(17, 31));
            else
                code = 5'($urandom_range(1, 16));
            len_word      = {$urandom, $urandom};
            len_word[4:0] = code;
            set_pattern(lo, hi, len_word);
            no_idle     = (phase_no == 2);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS
                   && items_sent - rand_start < RANDOM_ITEMS)
            begin
                if ($urandom_range(99) < 75)
                    build_id_stream(s);
                else
                    build_noise_stream(s);
                send_stream(s, 1'b1);
            end
            phase_no++;
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with no expectation waiting");
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (found !== want.found)
                    report_mismatch($sformatf("found %0b, expected %0b", found, want.found));
                if (string_start !== want.string_start)
                    report_mismatch($sformatf("string_start %0d, expected %0d",
                                              string_start, want.string_start));
                if (string_length !== want.string_length)
                    report_mismatch($sformatf("string_length %0d, expected %0d",
                                              string_length, want.string_length));
                if (resume_offset !== want.resume_offset)
                    report_mismatch($sformatf("resume_offset %0d, expected %0d",
                                              resume_offset, want.resume_offset));
            end
        end
        pop <= no_idle || ($urandom_range(99) >= 21);
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, pending_results.size());
        $display("** rom_id_string_finder: FAILED **");
        $finish;
    end

    initial
    begin : main
        pat_lo       = '0;
        pat_hi       = '0;
        pat_len_code = 5'd1;
        clear_stream();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_terminators();
        test_no_match();
        test_length_codes();
        test_rom_end();
        test_random_streams();
        drain();
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        $display("Sent %0d bytes in %0d streams under %0d pattern settings; %0d results checked.",
                 items_sent, streams_sent, pattern_settings, results_checked);
        $display("Covered terminators, rejections, length cap, length codes and stream ends.");
        if (errors == 0)
            $display("** rom_id_string_finder: PASSED **");
        else
            $display("** rom_id_string_finder: FAILED **");
        $finish;
    end

endmodule

### sim.f
src/ridsf_pkg.sv
src/ridsf_front.sv
src/ridsf_item_fifo.sv
src/ridsf_back.sv
src/rom_id_string_finder.sv
tb/rom_id_string_finder_tb.sv
